[hw/rtl/nalsp_pkg.sv]
// Shared types and constants of the Annex B NAL splitter.
`timescale 1ns / 1ps
`default_nettype none
package nalsp_pkg;

  localparam int unsigned MAX_UNIT_BYTES = 65535;
  localparam logic [15:0] LEN_CAP =
      16'((MAX_UNIT_BYTES < 65535) ? MAX_UNIT_BYTES : 65535);

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0]  START_BYTE = 8'h01;
  localparam logic [4:0]  TYPE_SLICE = 5'd1;
  localparam logic [4:0]  TYPE_IDR   = 5'd5;
  localparam logic [4:0]  TYPE_EOSEQ = 5'd10;
  localparam logic [4:0]  TYPE_SPSX  = 5'd15;

  typedef enum logic [3:0] {
    MODE_LEAD = 4'b0001,
    MODE_HEAD = 4'b0010,
    MODE_BODY = 4'b0100,
    MODE_SKIP = 4'b1000
  } scan_mode_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DROP = 2'd1,
    ST_PIC2 = 2'd2,
    ST_SPSX = 2'd3
  } status_e;

  // One queue entry: a unit result, optionally followed by a drop result, or a drop result alone.
  typedef struct packed {
    logic [7:0]  hdr;
    logic [15:0] len;
    logic        clip;
    status_e     status;
    logic [15:0] gap_max;
    logic [23:0] slices;
    logic        two;
  } entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

endpackage
`default_nettype wire

[hw/rtl/annexb_nal_splitter_with_stats.sv]
// Top level of the Annex B NAL splitter with slice statistics.
//
// Input stream: one payload byte per transfer on s_axis_tdata, s_axis_tlast
// on the final byte of a packet. Output stream: one result per transfer,
// unit header fields, length and running statistics on m_axis_tdata, the
// status code on m_axis_tuser, m_axis_tlast on the last result of a byte.
// Most bytes produce no result; a unit closes on the 01 of the next start
// code or on the packet's last byte. A start code ending a packet gives the
// open unit's result and a drop result (no drop after ST_PIC2), or a lone drop.
// Throughput: one byte per cycle while the queue has room (s_axis_tready high).
// A result enters the queue with its byte and is offered after earlier entries.
// A four-entry queue separates scanner and output stage; when the receiver
// stalls, bytes are still taken until the queue fills, then s_axis_tready
// drops. An entry with two results holds the output for two transfers.
// Reset returns the scanner to the leading-zero search and clears all
// statistics and the queue; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module annexb_nal_splitter_with_stats import nalsp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // data_byte[7:0]
  input  wire logic        s_axis_tlast,   // packet_last
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // unit_type[4:0], ref_idc[6:5], forbidden[7], unit_length[23:8],
  // length_clipped[24], max_rap_gap[40:25], slices_seen[64:41], zero pad
  output logic [71:0]      m_axis_tdata,
  output logic [1:0]       m_axis_tuser,   // status[1:0]
  output logic             m_axis_tlast    // run_last
);

  logic               in_accept, push, pop;
  entry_t             wentry, rentry, res;
  fifo_stat_t         fstat;
  logic [FIFO_CW-1:0] fcount;

  assign s_axis_tready = !fstat.full;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  nalsp_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .byte_i   (s_axis_tdata),
    .last_i   (s_axis_tlast),
    .push_o   (push),
    .entry_o  (wentry)
  );

  nalsp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wentry),
    .pop_i   (pop),
    .rdata_o (rentry),
    .stat_o  (fstat),
    .count_o (fcount)
  );

  nalsp_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .entry_i (rentry),
    .stat_i  (fstat),
    .ready_i (m_axis_tready),
    .pop_o   (pop),
    .valid_o (m_axis_tvalid),
    .last_o  (m_axis_tlast),
    .res_o   (res)
  );

  assign m_axis_tdata = {7'd0, res.slices, res.gap_max, res.clip, res.len,
                         res.hdr[7], res.hdr[6:5], res.hdr[4:0]};
  assign m_axis_tuser = res.status;

  a_drop_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_DROP) |-> m_axis_tlast)
    else $error("drop result not last of its byte");

  a_drop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_DROP) |->
      (m_axis_tdata[24:0] == 25'd0))
    else $error("drop result carries unit fields");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !fstat.full)
    else $error("queue push while full");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fcount <= FIFO_CW'(FIFO_DEPTH))
    else $error("queue count out of range");

  a_slices_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> !m_axis_tvalid ||
      (m_axis_tdata[64:41] >= $past(m_axis_tdata[64:41])))
    else $error("slice count went backwards");

endmodule
`default_nettype wire

[hw/rtl/nalsp_front.sv]
// Byte scanner: start code search, unit classification and statistics.
`timescale 1ns / 1ps
`default_nettype none
module nalsp_front import nalsp_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] byte_i,
  input  wire logic       last_i,
  output logic            push_o,
  output entry_t          entry_o
);

  scan_mode_e  mode_q, mode_d;
  logic [15:0] zr_q, zr_d, ub_q, ub_d, gap_q, gap_d, gmax_q, gmax_d;
  logic [7:0]  hdr_q, hdr_d;
  logic [23:0] slc_q, slc_d;
  logic        pip_q, pip_d;

  logic        fin, drop, second, fin_clip, start_hit, is_slice;
  logic [15:0] fin_len, zr_inc;
  logic [7:0]  fin_hdr;
  status_e     fin_status;

  always_comb begin
    mode_d     = mode_q;
    zr_d       = zr_q;
    ub_d       = ub_q;
    hdr_d      = hdr_q;
    gap_d      = gap_q;
    gmax_d     = gmax_q;
    slc_d      = slc_q;
    pip_d      = pip_q;
    fin        = 1'b0;
    drop       = 1'b0;
    second     = 1'b0;
    fin_len    = '0;
    fin_clip   = 1'b0;
    fin_hdr    = hdr_q;
    fin_status = ST_OK;
    is_slice   = 1'b0;
    zr_inc     = (zr_q == 16'hffff) ? zr_q : zr_q + 16'd1;
    start_hit  = (byte_i == START_BYTE) && (zr_q >= 16'd2);

    case (mode_q)
      MODE_LEAD: begin
        if (byte_i == 8'd0) begin
          zr_d = zr_inc;
          drop = last_i;
        end else if (start_hit) begin
          zr_d = '0;
          if (last_i) drop = 1'b1;
          else        mode_d = MODE_HEAD;
        end else begin
          drop   = 1'b1;
          mode_d = MODE_SKIP;
        end
      end
      MODE_HEAD: begin
        hdr_d   = byte_i;
        fin_hdr = byte_i;
        ub_d    = 16'd1;
        zr_d    = '0;
        mode_d  = MODE_BODY;
        if (last_i) begin
          fin      = 1'b1;
          fin_clip = (16'd1 >= LEN_CAP);
          fin_len  = fin_clip ? LEN_CAP : 16'd1;
        end
      end
      MODE_BODY: begin
        if (start_hit) begin
          fin      = 1'b1;
          fin_clip = (ub_q >= LEN_CAP);
          fin_len  = fin_clip ? LEN_CAP : ub_q - zr_q;
          mode_d   = MODE_HEAD;
          zr_d     = '0;
          second   = last_i;
        end else begin
          ub_d = (ub_q < LEN_CAP) ? ub_q + 16'd1 : ub_q;
          zr_d = (byte_i == 8'd0) ? zr_inc : '0;
          if (last_i) begin
            fin      = 1'b1;
            fin_clip = (ub_d >= LEN_CAP);
            fin_len  = fin_clip ? LEN_CAP : ub_d;
          end
        end
      end
      default: ;
    endcase

    if (fin) begin
      is_slice = (fin_hdr[4:0] == TYPE_SLICE) || (fin_hdr[4:0] == TYPE_IDR);
      if (is_slice) begin
        gap_d = (gap_q == 16'hffff) ? gap_q : gap_q + 16'd1;
        slc_d = (slc_q == 24'hffffff) ? slc_q : slc_q + 24'd1;
        if (pip_q) begin
          fin_status = ST_PIC2;
          mode_d     = MODE_SKIP;
        end else begin
          pip_d = 1'b1;
        end
      end else if (fin_hdr[4:0] != TYPE_EOSEQ) begin
        if (fin_hdr[4:0] == TYPE_SPSX) fin_status = ST_SPSX;
        gmax_d = (gmax_q < gap_q) ? gap_q : gmax_q;
        gap_d  = '0;
      end
    end

    if (last_i) begin
      mode_d = MODE_LEAD;
      zr_d   = '0;
      ub_d   = '0;
      pip_d  = 1'b0;
    end
  end

  always_comb begin
    entry_o.gap_max = gmax_d;
    entry_o.slices  = slc_d;
    if (fin) begin
      entry_o.hdr    = fin_hdr;
      entry_o.len    = fin_len;
      entry_o.clip   = fin_clip;
      entry_o.status = fin_status;
      entry_o.two    = second && (fin_status != ST_PIC2);
    end else begin
      entry_o.hdr    = '0;
      entry_o.len    = '0;
      entry_o.clip   = 1'b0;
      entry_o.status = ST_DROP;
      entry_o.two    = 1'b0;
    end
  end

  assign push_o = accept_i && (fin || drop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_LEAD;
      zr_q   <= '0;
      ub_q   <= '0;
      hdr_q  <= '0;
      gap_q  <= '0;
      gmax_q <= '0;
      slc_q  <= '0;
      pip_q  <= 1'b0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      zr_q   <= zr_d;
      ub_q   <= ub_d;
      hdr_q  <= hdr_d;
      gap_q  <= gap_d;
      gmax_q <= gmax_d;
      slc_q  <= slc_d;
      pip_q  <= pip_d;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/nalsp_fifo.sv]
// Short result queue between the scanner and the output stage.
`timescale 1ns / 1ps
`default_nettype none
module nalsp_fifo import nalsp_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  entry_t      wdata_i,
  input  wire logic   pop_i,
  output entry_t      rdata_o,
  output fifo_stat_t  stat_o,
  output logic [FIFO_CW-1:0] count_o
);

  entry_t               mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wp_q, wp_d, rp_q, rp_d;
  logic [FIFO_CW-1:0]   cnt_q, cnt_d;
  logic                 do_push, do_pop;

  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == FIFO_CW'(FIFO_DEPTH));
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign rdata_o      = mem_q[rp_q];
  assign count_o      = cnt_q;

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (do_push) wp_d = (wp_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wp_q + 1'b1;
    if (do_pop)  rp_d = (rp_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rp_q + 1'b1;
    if (do_push && !do_pop)      cnt_d = cnt_q + 1'b1;
    else if (do_pop && !do_push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wp_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/nalsp_back.sv]
// Output stage: turns queue entries into one or two result transfers.
`timescale 1ns / 1ps
`default_nettype none
module nalsp_back import nalsp_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  entry_t     entry_i,
  input  fifo_stat_t stat_i,
  input  wire logic  ready_i,
  output logic       pop_o,
  output logic       valid_o,
  output logic       last_o,
  output entry_t     res_o
);

  logic phase_q, phase_d;
  logic xfer;

  assign valid_o = !stat_i.empty;
  assign last_o  = !(entry_i.two && !phase_q);
  assign xfer    = valid_o && ready_i;
  assign pop_o   = xfer && last_o;

  always_comb begin
    res_o = entry_i;
    if (phase_q) begin
      res_o.hdr    = '0;
      res_o.len    = '0;
      res_o.clip   = 1'b0;
      res_o.status = ST_DROP;
    end
    phase_d = phase_q;
    if (xfer) phase_d = !last_o;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) phase_q <= 1'b0;
    else         phase_q <= phase_d;
  end

endmodule
`default_nettype wire
